### hw/rtl/dmwbct_pkg.sv
// ----------------------------------------------------------------------------
// dmwbct_pkg
// Shared types, operation codes and constants of the write-back cache tag
// controller.
// ----------------------------------------------------------------------------
package dmwbct_pkg;

  localparam int ADDR_W              = 32;
  localparam int NUM_SETS_DEFAULT    = 64;
  localparam int BLOCK_WORDS_DEFAULT = 4;

  localparam int OP_W        = 3;
  localparam int LATENCY_W   = 11;
  localparam int SET_OUT_W   = 6;
  localparam int TAG_OUT_W   = 24;
  localparam int COUNT_W     = 32;
  localparam int HIT_LAT_W   = 8;
  localparam int MISS_PEN_W  = 10;
  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 10;

  // Operation codes; 6 and 7 are unused and do nothing
  localparam logic [OP_W-1:0] OP_LOAD     = 3'd0;
  localparam logic [OP_W-1:0] OP_STORE    = 3'd1;
  localparam logic [OP_W-1:0] OP_COMPLETE = 3'd2;
  localparam logic [OP_W-1:0] OP_CANCEL   = 3'd3;
  localparam logic [OP_W-1:0] OP_PROBE    = 3'd4;
  localparam logic [OP_W-1:0] OP_CLEAR    = 3'd5;

  // Configuration register indexes
  localparam logic [CFG_INDEX_W-1:0] REG_CACHE_ENABLED = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_HIT_LATENCY   = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_MISS_PENALTY  = 2'd2;

  localparam logic                  CACHE_ENABLED_RESET = 1'b1;
  localparam logic [HIT_LAT_W-1:0]  HIT_LATENCY_RESET   = 8'd1;
  localparam logic [MISS_PEN_W-1:0] MISS_PENALTY_RESET  = 10'd10;

  typedef struct packed {
    logic [OP_W-1:0]   operation;
    logic [ADDR_W-1:0] word_address;
    logic              fill_pending;
    logic              fill_dirty;
  } in_item_t;

  typedef struct packed {
    logic                 was_enabled;
    logic                 hit;
    logic [LATENCY_W-1:0] latency;
    logic                 writeback;
    logic                 fill_required;
    logic                 dirty_on_fill;
    logic [SET_OUT_W-1:0] set_index;
    logic [TAG_OUT_W-1:0] tag;
    logic                 can_start;
    logic [COUNT_W-1:0]   access_count;
    logic [COUNT_W-1:0]   hit_count;
    logic [COUNT_W-1:0]   writeback_count;
  } out_item_t;

  typedef struct packed {
    logic                  cache_enabled;
    logic [HIT_LAT_W-1:0]  hit_latency;
    logic [MISS_PEN_W-1:0] miss_penalty;
  } cfg_t;

  typedef enum logic [1:0] {
    ST_SWEEP,
    ST_IDLE,
    ST_LOOKUP
  } ctrl_state_t;

endpackage

### hw/rtl/dmwbct_tag_ram.sv
// ----------------------------------------------------------------------------
// dmwbct_tag_ram
// Per-set metadata store: one write port, one read port, registered read.
// ----------------------------------------------------------------------------
module dmwbct_tag_ram #(
  parameter int DEPTH   = 64,
  parameter int ENTRY_W = 51
) (
  input  logic                     clk,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [ENTRY_W-1:0]       rd_data,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [ENTRY_W-1:0]       wr_data
);

  logic [ENTRY_W-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### hw/rtl/dmwbct_ctrl.sv
// ----------------------------------------------------------------------------
// dmwbct_ctrl
// Read-modify-write sequencer: decodes the address, reads the set entry,
// evaluates the operation, writes the entry back and registers the result.
// Also runs the clearing sweep and keeps the statistics counters.
// ----------------------------------------------------------------------------
module dmwbct_ctrl
  import dmwbct_pkg::*;
#(
  parameter int NUM_SETS    = NUM_SETS_DEFAULT,
  parameter int BLOCK_WORDS = BLOCK_WORDS_DEFAULT
) (
  input  logic      clk,
  input  logic      rst,
  input  cfg_t      cfg,
  input  logic      in_valid,
  output logic      in_stall,
  input  in_item_t  in_item,
  output logic      out_valid,
  input  logic      out_stall,
  output out_item_t out_item
);

  localparam int OFFSET_BITS = $clog2(BLOCK_WORDS);
  localparam int SET_BITS    = $clog2(NUM_SETS);
  localparam int TAG_BITS    = ADDR_W - OFFSET_BITS - SET_BITS;
  localparam int ENTRY_W     = 3 + 2 * TAG_BITS;
  localparam logic [SET_BITS-1:0] LAST_SET = SET_BITS'(NUM_SETS - 1);

  ctrl_state_t state, state_next;
  logic [SET_BITS-1:0] sweep_idx;
  in_item_t            item;

  logic [COUNT_W-1:0] accesses_total, hits_total, writebacks_total;
  logic [COUNT_W-1:0] accesses_next, hits_next, writebacks_next;

  logic                accept, commit;
  logic                rd_en;
  logic [SET_BITS-1:0] rd_addr;
  logic [ENTRY_W-1:0]  rd_data;
  logic                wr_en;
  logic [SET_BITS-1:0] wr_addr;
  logic [ENTRY_W-1:0]  wr_data;

  logic [SET_BITS-1:0] set_idx;
  logic [TAG_BITS-1:0] tag;

  logic                lv, ld, pv;
  logic [TAG_BITS-1:0] ltag, ptag;
  logic                lv_n, ld_n, pv_n;
  logic [TAG_BITS-1:0] ltag_n, ptag_n;

  logic                 en, is_store, line_hit;
  logic                 do_write, do_clear;
  logic                 r_hit, r_wb, r_freq, r_dof, r_can;
  logic [LATENCY_W-1:0] r_lat;
  out_item_t            result;

  dmwbct_tag_ram #(
    .DEPTH   (NUM_SETS),
    .ENTRY_W (ENTRY_W)
  ) u_tag_ram (
    .clk     (clk),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (wr_data)
  );

  // Address decode of the held item
  assign set_idx = item.word_address[OFFSET_BITS +: SET_BITS];
  assign tag     = item.word_address[ADDR_W-1 -: TAG_BITS];

  assign {lv, ld, ltag, pv, ptag} = rd_data;

  // Operation evaluation on the entry read for the held item
  always_comb begin
    en       = cfg.cache_enabled;
    is_store = (item.operation == OP_STORE);
    line_hit = lv && (ltag == tag);
    lv_n     = lv;
    ld_n     = ld;
    ltag_n   = ltag;
    pv_n     = pv;
    ptag_n   = ptag;
    do_write = 1'b0;
    do_clear = 1'b0;
    r_hit    = 1'b0;
    r_lat    = '0;
    r_wb     = 1'b0;
    r_freq   = 1'b0;
    r_dof    = 1'b0;
    r_can    = 1'b0;
    accesses_next   = accesses_total;
    hits_next       = hits_total;
    writebacks_next = writebacks_total;
    case (item.operation)
      OP_LOAD, OP_STORE: begin
        if (en) begin
          accesses_next = accesses_total + 1'b1;
          if (line_hit) begin
            r_hit     = 1'b1;
            r_lat     = LATENCY_W'(cfg.hit_latency);
            hits_next = hits_total + 1'b1;
            if (is_store) begin
              ld_n     = 1'b1;
              do_write = 1'b1;
            end
          end else begin
            r_lat = LATENCY_W'(cfg.hit_latency) + LATENCY_W'(cfg.miss_penalty);
            if (lv && ld) begin
              r_wb            = 1'b1;
              writebacks_next = writebacks_total + 1'b1;
            end
            r_freq   = 1'b1;
            r_dof    = is_store;
            pv_n     = 1'b1;
            ptag_n   = tag;
            do_write = 1'b1;
          end
        end
      end
      OP_COMPLETE: begin
        if (en && item.fill_pending) begin
          lv_n     = 1'b1;
          ld_n     = item.fill_dirty;
          ltag_n   = tag;
          pv_n     = 1'b0;
          ptag_n   = '0;
          do_write = 1'b1;
        end
      end
      OP_CANCEL: begin
        if (en && item.fill_pending && pv && (ptag == tag)) begin
          pv_n     = 1'b0;
          ptag_n   = '0;
          do_write = 1'b1;
        end
      end
      OP_PROBE: begin
        r_can = !en || !pv;
      end
      OP_CLEAR: begin
        do_clear        = 1'b1;
        accesses_next   = '0;
        hits_next       = '0;
        writebacks_next = '0;
      end
      default: begin
      end
    endcase

    result.was_enabled     = en;
    result.hit             = r_hit;
    result.latency         = r_lat;
    result.writeback       = r_wb;
    result.fill_required   = r_freq;
    result.dirty_on_fill   = r_dof;
    result.set_index       = SET_OUT_W'(set_idx);
    result.tag             = TAG_OUT_W'(tag);
    result.can_start       = r_can;
    result.access_count    = accesses_next;
    result.hit_count       = hits_next;
    result.writeback_count = writebacks_next;
  end

  // Sequencer: next state and memory port control
  always_comb begin
    state_next = state;
    in_stall   = 1'b1;
    accept     = 1'b0;
    commit     = 1'b0;
    rd_en      = 1'b0;
    rd_addr    = in_item.word_address[OFFSET_BITS +: SET_BITS];
    wr_en      = 1'b0;
    wr_addr    = set_idx;
    wr_data    = {lv_n, ld_n, ltag_n, pv_n, ptag_n};
    case (state)
      ST_SWEEP: begin
        wr_en   = 1'b1;
        wr_addr = sweep_idx;
        wr_data = '0;
        if (sweep_idx == LAST_SET) begin
          state_next = ST_IDLE;
        end
      end
      ST_IDLE: begin
        in_stall = 1'b0;
        accept   = in_valid;
        rd_en    = in_valid;
        if (in_valid) begin
          state_next = ST_LOOKUP;
        end
      end
      ST_LOOKUP: begin
        // result waits here while the output register is still occupied
        if (!out_valid || !out_stall) begin
          commit     = 1'b1;
          wr_en      = do_write;
          state_next = do_clear ? ST_SWEEP : ST_IDLE;
        end
      end
      default: begin
        state_next = ST_SWEEP;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_SWEEP;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      sweep_idx <= '0;
    end else if (state == ST_SWEEP) begin
      sweep_idx <= sweep_idx + 1'b1;
    end else begin
      sweep_idx <= '0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      item <= in_item;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      accesses_total   <= '0;
      hits_total       <= '0;
      writebacks_total <= '0;
    end else if (commit) begin
      accesses_total   <= accesses_next;
      hits_total       <= hits_next;
      writebacks_total <= writebacks_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (commit) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (commit) begin
      out_item <= result;
    end
  end

endmodule

### hw/rtl/direct_mapped_writeback_cache_tags.sv
// ----------------------------------------------------------------------------
// direct_mapped_writeback_cache_tags
// Tag and metadata controller of a direct-mapped write-back cache.
// ----------------------------------------------------------------------------
// Each result is registered from the lookup state once the output register is free.
// A new item is taken only after the previous one has done its read-modify-write
//   of the single-port-pair metadata memory (read in idle, write back in lookup).
// Reset and the clear operation both start a sweep over all NUM_SETS entries that
//   zeroes the metadata memory; no item is taken meanwhile, config still is.
// Reset also restores the configuration registers and zeroes the counters.
module direct_mapped_writeback_cache_tags
  import dmwbct_pkg::*;
#(
  parameter int NUM_SETS    = NUM_SETS_DEFAULT,
  parameter int BLOCK_WORDS = BLOCK_WORDS_DEFAULT
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  in_item_t               in_item,
  output logic                   out_valid,
  input  logic                   out_stall,
  output out_item_t              out_item,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data
);

  cfg_t cfg;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.cache_enabled <= CACHE_ENABLED_RESET;
      cfg.hit_latency   <= HIT_LATENCY_RESET;
      cfg.miss_penalty  <= MISS_PENALTY_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_CACHE_ENABLED: cfg.cache_enabled <= cfg_data[0];
        REG_HIT_LATENCY:   cfg.hit_latency   <= cfg_data[HIT_LAT_W-1:0];
        REG_MISS_PENALTY:  cfg.miss_penalty  <= cfg_data[MISS_PEN_W-1:0];
        default: begin
        end
      endcase
    end
  end

  dmwbct_ctrl #(
    .NUM_SETS    (NUM_SETS),
    .BLOCK_WORDS (BLOCK_WORDS)
  ) u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .cfg       (cfg),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_item  (out_item)
  );

endmodule

### tb/cache_tags_checker.sv
// ----------------------------------------------------------------------------
// cache_tags_checker
// Watches the operation, result and register ports of the cache tag
// controller. Keeps its own copy of the tag, dirty and pending-fill arrays
// and the counters, works out each result at the operation transfer, and
// compares every result transfer field by field in order.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module cache_tags_checker
  import dmwbct_pkg::*;
(
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  input  logic                   in_stall,
  input  in_item_t               in_item,
  input  logic                   out_valid,
  input  logic                   out_stall,
  input  out_item_t              out_item,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  output int                     outstanding,
  output int                     mismatches,
  output int                     results_checked,
  output int                     hits_seen,
  output int                     writebacks_seen
);

  localparam int SETS  = NUM_SETS_DEFAULT;
  localparam int OFS_W = $clog2(BLOCK_WORDS_DEFAULT);
  localparam int SET_W = $clog2(NUM_SETS_DEFAULT);

  logic                  enabled_q;
  logic [HIT_LAT_W-1:0]  hit_lat_q;
  logic [MISS_PEN_W-1:0] miss_pen_q;

  logic                 line_ok    [SETS];
  logic                 line_mod   [SETS];
  logic [TAG_OUT_W-1:0] line_tags  [SETS];
  logic                 fill_open  [SETS];
  logic [TAG_OUT_W-1:0] fill_tags  [SETS];
  logic [COUNT_W-1:0]   n_access, n_hit, n_wb;

  out_item_t expected_results[$];
  out_item_t want;

  initial begin
    outstanding     = 0;
    mismatches      = 0;
    results_checked = 0;
    hits_seen       = 0;
    writebacks_seen = 0;
  end

  function automatic void wipe_cache();
    for (int s = 0; s < SETS; s++) begin
      line_ok[s]   = 1'b0;
      line_mod[s]  = 1'b0;
      line_tags[s] = '0;
      fill_open[s] = 1'b0;
      fill_tags[s] = '0;
    end
    n_access = '0;
    n_hit    = '0;
    n_wb     = '0;
  endfunction

  // Applies one operation to the shadow state and returns the result it gives
  function automatic out_item_t predict_cache_result(in_item_t op);
    out_item_t            r;
    logic [SET_W-1:0]     set;
    logic [TAG_OUT_W-1:0] tag;
    logic [ADDR_W-1:0]    blk;
    blk = op.word_address >> OFS_W;
    set = blk[SET_W-1:0];
    tag = TAG_OUT_W'(blk >> SET_W);
    r = '0;
    r.was_enabled = enabled_q;
    r.set_index   = set;
    r.tag         = tag;
    case (op.operation)
      OP_LOAD, OP_STORE: begin
        if (enabled_q) begin
          n_access++;
          if (line_ok[set] && line_tags[set] == tag) begin
            r.hit     = 1'b1;
            r.latency = LATENCY_W'(hit_lat_q);
            n_hit++;
            if (op.operation == OP_STORE) line_mod[set] = 1'b1;
          end else begin
            r.latency = LATENCY_W'(hit_lat_q) + LATENCY_W'(miss_pen_q);
            if (line_ok[set] && line_mod[set]) begin
              r.writeback = 1'b1;
              n_wb++;
            end
            r.fill_required = 1'b1;
            r.dirty_on_fill = (op.operation == OP_STORE);
            fill_open[set]  = 1'b1;
            fill_tags[set]  = tag;
          end
        end
      end
      OP_COMPLETE: begin
        if (enabled_q && op.fill_pending) begin
          line_ok[set]   = 1'b1;
          line_mod[set]  = op.fill_dirty;
          line_tags[set] = tag;
          fill_open[set] = 1'b0;
          fill_tags[set] = '0;
        end
      end
      OP_CANCEL: begin
        if (enabled_q && op.fill_pending && fill_open[set] && fill_tags[set] == tag) begin
          fill_open[set] = 1'b0;
          fill_tags[set] = '0;
        end
      end
      OP_PROBE: r.can_start = !enabled_q || !fill_open[set];
      OP_CLEAR: wipe_cache();
      default: ;
    endcase
    r.access_count    = n_access;
    r.hit_count       = n_hit;
    r.writeback_count = n_wb;
    return r;
  endfunction

  task automatic report_mismatch(input string field, input logic [31:0] got,
                                 input logic [31:0] exp_val);
    if (mismatches < 40)
      $display("[%0t] mismatch on %s: got 0x%0h, expected 0x%0h (result %0d)",
               $realtime, field, got, exp_val, results_checked);
    mismatches++;
  endtask

  always @(posedge clk) begin
    if (rst) begin
      enabled_q  = CACHE_ENABLED_RESET;
      hit_lat_q  = HIT_LATENCY_RESET;
      miss_pen_q = MISS_PENALTY_RESET;
      wipe_cache();
      expected_results.delete();
      outstanding <= 0;
    end else begin
      if (out_valid && !out_stall) begin
        if (expected_results.size() == 0) begin
          report_mismatch("result transfer with nothing pending", 32'd1, 32'd0);
        end else begin
          want = expected_results.pop_front();
          if (out_item.was_enabled != want.was_enabled)
            report_mismatch("was_enabled", 32'(out_item.was_enabled),
                            32'(want.was_enabled));
          if (out_item.hit != want.hit)
            report_mismatch("hit", 32'(out_item.hit), 32'(want.hit));
          if (out_item.latency != want.latency)
            report_mismatch("latency", 32'(out_item.latency), 32'(want.latency));
          if (out_item.writeback != want.writeback)
            report_mismatch("writeback", 32'(out_item.writeback),
                            32'(want.writeback));
          if (out_item.fill_required != want.fill_required)
            report_mismatch("fill_required", 32'(out_item.fill_required),
                            32'(want.fill_required));
          if (out_item.dirty_on_fill != want.dirty_on_fill)
            report_mismatch("dirty_on_fill", 32'(out_item.dirty_on_fill),
                            32'(want.dirty_on_fill));
          if (out_item.set_index != want.set_index)
            report_mismatch("set_index", 32'(out_item.set_index),
                            32'(want.set_index));
          if (out_item.tag != want.tag)
            report_mismatch("tag", 32'(out_item.tag), 32'(want.tag));
          if (out_item.can_start != want.can_start)
            report_mismatch("can_start", 32'(out_item.can_start),
                            32'(want.can_start));
          if (out_item.access_count != want.access_count)
            report_mismatch("access_count", out_item.access_count, want.access_count);
          if (out_item.hit_count != want.hit_count)
            report_mismatch("hit_count", out_item.hit_count, want.hit_count);
          if (out_item.writeback_count != want.writeback_count)
            report_mismatch("writeback_count", out_item.writeback_count,
                            want.writeback_count);
          results_checked++;
          if (want.hit) hits_seen++;
          if (want.writeback) writebacks_seen++;
        end
      end
      if (in_valid && !in_stall)
        expected_results.push_back(predict_cache_result(in_item));
      // register writes land after any operation taken at the same edge
      if (cfg_we) begin
        case (cfg_index)
          REG_CACHE_ENABLED: enabled_q  = cfg_data[0];
          REG_HIT_LATENCY:   hit_lat_q  = cfg_data[HIT_LAT_W-1:0];
          REG_MISS_PENALTY:  miss_pen_q = cfg_data[MISS_PEN_W-1:0];
          default: ;
        endcase
      end
      outstanding <= expected_results.size();
    end
  end

endmodule

### tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Stimulus and verdict for the write-back cache tag controller: a directed
// pass over the operations and corner addresses, then random load/store,
// fill and probe sequences under a series of register settings and
// handshake idling patterns. Checking lives in cache_tags_checker.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb
  import dmwbct_pkg::*;
();

  localparam int CYCLE_LIMIT  = 300000;
  localparam int SEG_ITEMS    = 200;
  localparam int NUM_SEGMENTS = 8;

  // operation codes with no defined action
  localparam logic [OP_W-1:0] OP_SPARE_LO = 3'd6;
  localparam logic [OP_W-1:0] OP_SPARE_HI = 3'd7;

  logic                   clk;
  logic                   rst       = 1'b1;
  logic                   in_valid  = 1'b0;
  logic                   in_stall;
  in_item_t               in_item   = '0;
  logic                   out_valid;
  logic                   out_stall = 1'b0;
  out_item_t              out_item;
  logic                   cfg_we    = 1'b0;
  logic [CFG_INDEX_W-1:0] cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_data  = '0;

  int outstanding, mismatches, results_checked, hits_seen, writebacks_seen;
  int send_idle_pct = 7;
  int recv_idle_pct = 51;
  int ops_sent      = 0;
  int settings_used = 0;
  int cycle_count   = 0;

  logic [TAG_OUT_W-1:0] tag_pool[4];
  logic [SET_OUT_W-1:0] set_base;

  direct_mapped_writeback_cache_tags dut (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
    .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  cache_tags_checker chk (
    .clk(clk), .rst(rst),
    .in_valid(in_valid), .in_stall(in_stall), .in_item(in_item),
    .out_valid(out_valid), .out_stall(out_stall), .out_item(out_item),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .outstanding(outstanding), .mismatches(mismatches),
    .results_checked(results_checked), .hits_seen(hits_seen),
    .writebacks_seen(writebacks_seen)
  );

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  always @(posedge clk) begin
    out_stall <= ($urandom_range(99) < recv_idle_pct);
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results still pending", cycle_count,
               outstanding);
      $display("Simulation FAILED");
      $finish;
    end
  end

  task automatic issue_op(input logic [OP_W-1:0] op, input logic [ADDR_W-1:0] addr,
                          input logic fp, input logic fd);
    in_item_t it;
    it.operation    = op;
    it.word_address = addr;
    it.fill_pending = fp;
    it.fill_dirty   = fd;
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_item  <= it;
    do @(posedge clk); while (in_stall);
    ops_sent++;
  endtask

  // hold off the sender until every result has come back
  task automatic drain_results();
    in_valid <= 1'b0;
    do @(posedge clk); while (outstanding != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic program_regs(input logic en, input logic [HIT_LAT_W-1:0] hl,
                              input logic [MISS_PEN_W-1:0] mp);
    logic [CFG_DATA_W-1:0] junk;
    junk = CFG_DATA_W'($urandom);
    cfg_we    <= 1'b1;
    cfg_index <= REG_CACHE_ENABLED;
    cfg_data  <= {junk[CFG_DATA_W-1:1], en};
    @(posedge clk);
    cfg_index <= REG_HIT_LATENCY;
    cfg_data  <= {junk[CFG_DATA_W-1:HIT_LAT_W], hl};
    @(posedge clk);
    cfg_index <= REG_MISS_PENALTY;
    cfg_data  <= mp;
    @(posedge clk);
    cfg_we <= 1'b0;
    settings_used++;
  endtask

  // addresses drawn from a few tags and, half the time, a narrow run of sets, so lines get reused
  function automatic logic [ADDR_W-1:0] pool_addr();
    logic [SET_OUT_W-1:0] set;
    logic [1:0]           ofs;
    set = ($urandom_range(1) == 0) ? set_base + SET_OUT_W'($urandom_range(3))
                                   : SET_OUT_W'($urandom_range(63));
    ofs = 2'($urandom);
    return {tag_pool[2'($urandom_range(3))], set, ofs};
  endfunction

  task automatic random_burst();
    logic [ADDR_W-1:0] addr;
    logic [OP_W-1:0]   op;
    logic              is_store;
    int                roll;
    roll = $urandom_range(99);
    addr = pool_addr();
    is_store = 1'($urandom_range(1));
    if (roll < 70) begin
      // access, optional probe, then usually a fill or a cancel for it
      issue_op(is_store ? OP_STORE : OP_LOAD, addr, 1'($urandom), 1'($urandom));
      if ($urandom_range(99) < 30)
        issue_op(OP_PROBE, addr, 1'($urandom), 1'($urandom));
      roll = $urandom_range(99);
      if (roll < 65)
        issue_op(OP_COMPLETE, addr, 1'b1,
                 is_store | ($urandom_range(9) == 0));
      else if (roll < 80)
        issue_op(OP_CANCEL, addr, 1'b1, 1'($urandom));
      else if (roll < 88)
        issue_op(OP_CANCEL, pool_addr(), 1'b1, 1'($urandom));
      else if (roll < 93)
        issue_op(($urandom_range(1) == 0) ? OP_COMPLETE : OP_CANCEL, addr, 1'b0,
                 1'($urandom));
    end else if (roll < 94) begin
      issue_op(is_store ? OP_STORE : OP_LOAD, addr, 1'($urandom), 1'($urandom));
    end else begin
      op = OP_W'($urandom);
      // clears are costly, keep them rare
      if (op == OP_CLEAR && $urandom_range(9) != 0) op = OP_PROBE;
      issue_op(op, $urandom, 1'($urandom), 1'($urandom));
    end
  endtask

  initial begin
    int seg_start;
    repeat (2) @(posedge clk);
    rst <= 1'b0;

    // directed pass, reset register values
    issue_op(OP_LOAD,     32'h0000_0000, 1'b0, 1'b0);
    issue_op(OP_PROBE,    32'h0000_0000, 1'b0, 1'b0);
    issue_op(OP_COMPLETE, 32'h0000_0000, 1'b1, 1'b0);
    issue_op(OP_LOAD,     32'h0000_0003, 1'b1, 1'b1);
    issue_op(OP_STORE,    32'h0000_0000, 1'b0, 1'b0);
    issue_op(OP_LOAD,     32'hFFFF_FFFF, 1'b1, 1'b1);
    issue_op(OP_CANCEL,   32'h0000_00FC, 1'b1, 1'b0);  // tag mismatch
    issue_op(OP_CANCEL,   32'hFFFF_FFFC, 1'b0, 1'b0);  // no fill claimed
    issue_op(OP_PROBE,    32'hFFFF_FFFF, 1'b0, 1'b0);
    issue_op(OP_CANCEL,   32'hFFFF_FFFF, 1'b1, 1'b1);
    issue_op(OP_PROBE,    32'hFFFF_FFFF, 1'b1, 1'b1);
    issue_op(OP_STORE,    32'hFFFF_FF00, 1'b0, 1'b0);  // dirty victim
    issue_op(OP_COMPLETE, 32'hFFFF_FF00, 1'b1, 1'b1);
    issue_op(OP_COMPLETE, 32'h0000_0100, 1'b0, 1'b1);
    issue_op(OP_LOAD,     32'h0000_0100, 1'b0, 1'b0);
    issue_op(OP_SPARE_LO, 32'hAAAA_AAAA, 1'b1, 1'b1);
    issue_op(OP_SPARE_HI, 32'h5555_5555, 1'b0, 1'b0);
    issue_op(OP_CLEAR,    32'h1234_5678, 1'b1, 1'b0);
    issue_op(OP_LOAD,     32'hFFFF_FF00, 1'b0, 1'b0);
    drain_results();
    // bypass: every operation with lookups off, clear still acts
    program_regs(1'b0, 8'd37, 10'd500);
    issue_op(OP_LOAD,     32'hFFFF_FF00, 1'b0, 1'b0);
    issue_op(OP_STORE,    32'h0000_0100, 1'b1, 1'b1);
    issue_op(OP_COMPLETE, 32'h0000_0200, 1'b1, 1'b1);
    issue_op(OP_CANCEL,   32'hFFFF_FF00, 1'b1, 1'b0);
    issue_op(OP_PROBE,    32'hFFFF_FF00, 1'b0, 1'b0);
    issue_op(OP_CLEAR,    32'h0000_0000, 1'b0, 1'b0);

    for (int seg = 0; seg < NUM_SEGMENTS; seg++) begin
      drain_results();
      send_idle_pct = (seg < 3) ? 7 : (seg < 6) ? 51 : 0;
      recv_idle_pct = (seg < 3) ? 51 : (seg < 6) ? 7 : 0;
      case (seg)
        0: program_regs(1'b1, 8'd255, 10'd1023);
        1: program_regs(1'b1, 8'd0, 10'd0);
        2: program_regs(1'b0, HIT_LAT_W'($urandom), MISS_PEN_W'($urandom));
        3: program_regs(1'b1, HIT_LAT_W'($urandom), MISS_PEN_W'($urandom));
        4: program_regs(1'b1, 8'd1, 10'd10);
        5: program_regs(1'b1, HIT_LAT_W'($urandom), 10'd1023);
        6: program_regs(1'b1, 8'd255, 10'd0);
        default: program_regs(1'b1, HIT_LAT_W'($urandom), MISS_PEN_W'($urandom));
      endcase
      tag_pool[0] = TAG_OUT_W'($urandom);
      tag_pool[1] = ~tag_pool[0];
      tag_pool[2] = ($urandom_range(1) == 0) ? '0 : '1;
      tag_pool[3] = TAG_OUT_W'($urandom);
      set_base    = SET_OUT_W'($urandom);
      seg_start   = ops_sent;
      while (ops_sent - seg_start < SEG_ITEMS) begin
        if (seg == 4 && ops_sent - seg_start >= SEG_ITEMS / 2 &&
            ops_sent - seg_start < SEG_ITEMS / 2 + 3)
          drain_results();
        random_burst();
      end
    end

    drain_results();
    repeat (10) @(posedge clk);
    $display("Ran %0d operations under %0d register settings and three idling patterns",
             ops_sent, settings_used);
    $display("%0d results checked, %0d hits and %0d dirty evictions among them",
             results_checked, hits_seen, writebacks_seen);
    if (mismatches == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches", mismatches);
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule
